// ----- hdl/procedural_gradient_blend_top_assert.svh -----
// Assertion macros for the gradient blend block
`ifndef PROCEDURAL_GRADIENT_BLEND_TOP_ASSERT_SVH
`define PROCEDURAL_GRADIENT_BLEND_TOP_ASSERT_SVH
// implication checked every clock outside reset
`define PGB_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("%s failed", "label");
// implication checked in the cycle after the antecedent
`define PGB_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("%s failed", "label");
`endif

// ----- hdl/pgb_pkg.sv -----
// Package: types, constants and tables of the gradient blend block
`timescale 1ns / 1ps
`default_nettype none
package pgb_pkg;
   localparam int ONE_Q15 = 32768;
   localparam int CORDIC_STEPS = 16;
   localparam int ACC_W = 26;

   typedef enum logic [2:0] {
      MODE_LINEAR = 3'd0,
      MODE_QUAD = 3'd1,
      MODE_EASE = 3'd2,
      MODE_DIAG = 3'd3,
      MODE_SPHERE = 3'd4,
      MODE_QSPHERE = 3'd5,
      MODE_RADIAL = 3'd6,
      MODE_UNDEF = 3'd7
   } mode_type;

   localparam logic [0:0] REG_MODE = 1'b0;
   localparam logic [0:0] REG_SWAP = 1'b1;

   // atan(2^-i) in 2^-24 turn
   function automatic logic signed [ACC_W-1:0] atan_turn(input logic [3:0] i);
      logic signed [ACC_W-1:0] r;
      unique case (i)
         4'd0: r = 26'sd2097152;
         4'd1: r = 26'sd1238021;
         4'd2: r = 26'sd654136;
         4'd3: r = 26'sd332050;
         4'd4: r = 26'sd166669;
         4'd5: r = 26'sd83416;
         4'd6: r = 26'sd41718;
         4'd7: r = 26'sd20860;
         4'd8: r = 26'sd10430;
         4'd9: r = 26'sd5215;
         4'd10: r = 26'sd2608;
         4'd11: r = 26'sd1304;
         4'd12: r = 26'sd652;
         4'd13: r = 26'sd326;
         4'd14: r = 26'sd163;
         default: r = 26'sd81;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- hdl/pgb_req_if.sv -----
// Stream interfaces: point words in, blend words out
`timescale 1ns / 1ps
`default_nettype none
interface pgb_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;
   logic signed [15:0] coord_z;
   modport source (output valid, coord_x, coord_y, coord_z, input ready);
   modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface pgb_rsp_if;
   logic valid;
   logic ready;
   logic [15:0] blend_value;
   modport source (output valid, blend_value, input ready);
   modport sink (input valid, blend_value, output ready);
endinterface
`default_nettype wire

// ----- hdl/pgb_sqrt.sv -----
// Pipelined integer square root, two result bits per stage
`timescale 1ns / 1ps
`default_nettype none
module pgb_sqrt (
   input wire logic clock,
   input wire logic adv,
   input wire logic [37:0] rad_in,
   output logic [18:0] root_out
);
   import pgb_pkg::*;
   localparam int NST = 10;
   logic [37:0] rem_ff [NST+1];
   logic [18:0] res_ff [NST+1];

   always_comb begin
      rem_ff[0] = rad_in;
      res_ff[0] = '0;
   end

   // restoring square root, digit pairs from the top; each stage does two digits
   for (genvar s = 0; s < NST; s++) begin : g_st
      logic [37:0] rem_in;
      logic [18:0] res_in;
      logic [37:0] rem_pipe_ff;
      logic [18:0] res_pipe_ff;
      always_comb begin
         logic [39:0] trial;
         rem_in = rem_ff[s];
         res_in = res_ff[s];
         for (int k = 0; k < 2; k++) begin
            if (2*s + k < 19) begin
               trial = ({21'd0, res_in} << ((18-(2*s+k)) + 1))
                     | (40'd1 << (2*(18-(2*s+k))));
               if ({2'b00, rem_in} >= trial) begin
                  rem_in = rem_in - trial[37:0];
                  res_in = res_in | (19'd1 << (18-(2*s+k)));
               end
            end
         end
      end
      if (s % 2 == 1 || s == NST-1) begin : g_reg
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_pipe_ff <= rem_in;
               res_pipe_ff <= res_in;
            end
         end
      end else begin : g_cmb
         always_comb begin
            rem_pipe_ff = rem_in;
            res_pipe_ff = res_in;
         end
      end
      always_comb begin
         rem_ff[s+1] = rem_pipe_ff;
         res_ff[s+1] = res_pipe_ff;
      end
   end
   assign root_out = res_ff[NST];
endmodule
`default_nettype wire

// ----- hdl/pgb_cordic.sv -----
// Pipelined CORDIC vectoring, two iterations per step, a register after every second step
`timescale 1ns / 1ps
`default_nettype none
module pgb_cordic (
   input wire logic clock,
   input wire logic adv,
   input wire logic signed [15:0] c1,
   input wire logic signed [15:0] c2,
   output logic signed [pgb_pkg::ACC_W-1:0] angle_out
);
   import pgb_pkg::*;
   localparam int XW = 27;
   localparam int NST = CORDIC_STEPS / 2;
   logic signed [XW-1:0] x_ff [NST+1];
   logic signed [XW-1:0] y_ff [NST+1];
   logic signed [ACC_W-1:0] a_ff [NST+1];

   always_comb begin
      logic signed [XW-1:0] x0, y0;
      x0 = XW'(c1) <<< 8;
      y0 = XW'(c2) <<< 8;
      if (x0 < 0) begin
         if (y0 >= 0) begin
            x_ff[0] = y0;
            y_ff[0] = -x0;
            a_ff[0] = ACC_W'(1 << 22);
         end else begin
            x_ff[0] = -y0;
            y_ff[0] = x0;
            a_ff[0] = -ACC_W'(1 << 22);
         end
      end else begin
         x_ff[0] = x0;
         y_ff[0] = y0;
         a_ff[0] = '0;
      end
   end

   for (genvar s = 0; s < NST; s++) begin : g_st
      logic signed [XW-1:0] x_in, y_in;
      logic signed [ACC_W-1:0] a_in;
      logic signed [XW-1:0] x_r_ff, y_r_ff;
      logic signed [ACC_W-1:0] a_r_ff;
      always_comb begin
         logic signed [XW-1:0] dx, dy;
         x_in = x_ff[s];
         y_in = y_ff[s];
         a_in = a_ff[s];
         for (int k = 0; k < 2; k++) begin
            dx = y_in >>> (2*s + k);
            dy = x_in >>> (2*s + k);
            if (y_in > 0) begin
               x_in = x_in + dx;
               y_in = y_in - dy;
               a_in = a_in + atan_turn(4'(2*s + k));
            end else begin
               x_in = x_in - dx;
               y_in = y_in + dy;
               a_in = a_in - atan_turn(4'(2*s + k));
            end
         end
      end
      if (s % 2 == 1) begin : g_reg
         always_ff @(posedge clock) begin
            if (adv) begin
               x_r_ff <= x_in;
               y_r_ff <= y_in;
               a_r_ff <= a_in;
            end
         end
      end else begin : g_cmb
         always_comb begin
            x_r_ff = x_in;
            y_r_ff = y_in;
            a_r_ff = a_in;
         end
      end
      always_comb begin
         x_ff[s+1] = x_r_ff;
         y_ff[s+1] = y_r_ff;
         a_ff[s+1] = a_r_ff;
      end
   end
   assign angle_out = a_ff[NST];
endmodule
`default_nettype wire

// ----- hdl/procedural_gradient_blend_top.sv -----
// Top level of the gradient blend block: pipeline control, math stages, csr
//
// Usage: points enter on the req channel (valid/ready, one word per cycle while
// the pipe advances) and blend values leave on the rsp channel in the same
// order. blend_mode and swap_axes are written through the csr APB port (byte
// addresses 0 and 4); the user must write them only while the block is idle,
// which the block itself does not enforce. pready is always high, reads return
// the registers. Depth: seven register stages from the accepting edge to rsp.
// Throughput is one point per clock while the receiver does not stall: the sqrt
// and CORDIC units are split into register stages and the whole pipe advances
// together. When the receiver stalls, the pipe holds as long as its last stage
// is full; req_ready follows "output stage empty or taken" and nothing is lost.
// Reset (synchronous, active high) clears all valid bits and the registers
// to linear mode, no swap.
`timescale 1ns / 1ps
`default_nettype none
`include "procedural_gradient_blend_top_assert.svh"
module procedural_gradient_blend_top (
   input wire logic clock,
   input wire logic reset,
   pgb_req_if.sink req,
   pgb_rsp_if.source rsp,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [2:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import pgb_pkg::*;
   localparam int LAT = 7;

   mode_type mode_ff;
   logic swap_ff;
   logic [LAT-1:0] vld_ff;
   logic adv;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LINEAR;
         swap_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == REG_MODE) mode_ff <= mode_type'(csr_pwdata[2:0]);
         else swap_ff <= csr_pwdata[0];
      end
   end
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_MODE) csr_prdata[2:0] = mode_ff;
      else csr_prdata[0] = swap_ff;
   end

   assign adv = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = adv;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[LAT-2:0], req.valid};
   end

   // stage 0: swap, linear terms and squares
   logic signed [15:0] c1, c2;
   assign c1 = swap_ff ? req.coord_y : req.coord_x;
   assign c2 = swap_ff ? req.coord_x : req.coord_y;
   logic signed [18:0] b_ff;
   logic signed [18:0] diag_ff;
   logic [31:0] sq1_ff, sq2_ff, sq3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         b_ff <= (19'(c1) + 19'sd4096) <<< 2;
         diag_ff <= (19'sd8192 + 19'(c1) + 19'(c2)) <<< 1;
         sq1_ff <= 32'(c1 * c1);
         sq2_ff <= 32'(c2 * c2);
         sq3_ff <= 32'(req.coord_z * req.coord_z);
      end
   end

   // stage 1: sphere sum, b^2, b clamp
   logic [37:0] rad_arg;
   logic [33:0] ssum;
   assign ssum = 34'(sq1_ff) + 34'(sq2_ff) + 34'(sq3_ff);
   assign rad_arg = {ssum[31:0], 6'd0};
   logic [15:0] bc_ff;
   logic [30:0] b2_ff;
   logic bneg_ff, bone_ff;
   logic signed [18:0] diag1_ff, blin_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         bneg_ff <= b_ff <= 0;
         bone_ff <= b_ff >= 19'sd32768;
         bc_ff <= b_ff[15:0];
         b2_ff <= 31'(b_ff[15:0] * b_ff[15:0]);
         diag1_ff <= diag_ff;
         blin_ff <= b_ff;
      end
   end

   // stage 2: b^2 rounded and b^3 product
   logic [46:0] b3_ff;
   logic [30:0] b2b_ff;
   logic [15:0] bsq_ff;
   logic bneg2_ff, bone2_ff, bzero2_ff;
   logic signed [18:0] diag2_ff, blin2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         b3_ff <= 47'(b2_ff * bc_ff);
         b2b_ff <= b2_ff;
         bsq_ff <= 16'((32'(b2_ff) + 32'd16384) >> 15);
         bneg2_ff <= blin_ff < 0;
         bzero2_ff <= bneg_ff;
         bone2_ff <= bone_ff;
         diag2_ff <= diag1_ff;
         blin2_ff <= blin_ff;
      end
   end

   // stage 3: easing combine
   logic [15:0] ease_ff;
   logic [15:0] quad_ff;
   logic signed [18:0] diag3_ff, blin3_ff;
   always_ff @(posedge clock) begin
      logic [48:0] v;
      v = 49'(b2b_ff) * 49'd98304 - (49'(b3_ff) << 1);
      if (adv) begin
         if (bzero2_ff) ease_ff <= 16'd0;
         else if (bone2_ff) ease_ff <= 16'd32768;
         else ease_ff <= 16'((v + 49'(1 << 29)) >> 30);
         quad_ff <= bneg2_ff ? 16'd0 : (bone2_ff && blin2_ff > 19'sd32768 ? 16'hFFFF : bsq_ff);
         diag3_ff <= diag2_ff;
         blin3_ff <= blin2_ff;
      end
   end

   // sqrt runs stages 1..5, CORDIC stages 0..3 (root out at stage 6 input)
   logic [18:0] root;
   pgb_sqrt u_sqrt (.clock(clock), .adv(adv), .rad_in(rad_arg), .root_out(root));
   logic signed [ACC_W-1:0] ang;
   pgb_cordic u_cordic (.clock(clock), .adv(adv), .c1(c1), .c2(c2), .angle_out(ang));
   logic zero0;
   assign zero0 = (c1 == 0) && (c2 == 0);

   // carry the early results down to stage 6
   logic [15:0] ease4_ff, ease5_ff, quad4_ff, quad5_ff;
   logic signed [18:0] diag4_ff, diag5_ff, blin4_ff, blin5_ff;
   logic [16:0] rad_ff [2];
   logic [3:0] zero_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ease4_ff <= ease_ff;
         ease5_ff <= ease4_ff;
         quad4_ff <= quad_ff;
         quad5_ff <= quad4_ff;
         diag4_ff <= diag3_ff;
         diag5_ff <= diag4_ff;
         blin4_ff <= blin3_ff;
         blin5_ff <= blin4_ff;
         // origin flag travels alongside the CORDIC pipe
         zero_ff <= {zero_ff[2:0], zero0};
         rad_ff[0] <= zero_ff[3] ? 17'd16384 :
            17'(((ang + ACC_W'(256)) >>> 9) + ACC_W'(16384));
         rad_ff[1] <= rad_ff[0];
      end
   end

   // stage 6: sphere value from the root, and the mode mux
   logic [15:0] res_ff;
   logic [15:0] sph_in;
   assign sph_in = (root >= 19'd32768) ? 16'd0 : 16'(19'd32768 - root);
   always_ff @(posedge clock) begin
      logic [31:0] sp2;
      logic [15:0] r;
      sp2 = 32'(sph_in) * 32'(sph_in);
      if (adv) begin
         unique case (mode_ff)
            MODE_QUAD: r = quad5_ff;
            MODE_EASE: r = ease5_ff;
            MODE_DIAG: r = diag5_ff < 0 ? 16'd0 :
               (diag5_ff > 19'sd32768 ? 16'd32768 : diag5_ff[15:0]);
            MODE_SPHERE: r = sph_in;
            MODE_QSPHERE: r = 16'((sp2 + 32'd16384) >> 15);
            MODE_RADIAL: r = rad_ff[1][16] ? 16'd0 :
               (rad_ff[1] > 17'd32768 ? 16'd32768 : rad_ff[1][15:0]);
            default: r = blin5_ff < 0 ? 16'd0 :
               (blin5_ff > 19'sd32768 ? 16'd32768 : blin5_ff[15:0]);
         endcase
         if (mode_ff == MODE_QUAD && quad5_ff > 16'd32768) r = 16'd32768;
         res_ff <= r;
      end
   end
   assign rsp.blend_value = res_ff;
   assign rsp.valid = vld_ff[LAT-1];

   `PGB_ASSERT_IMP(a_range, clock, reset, rsp.valid, rsp.blend_value <= 16'd32768)
   `PGB_ASSERT_NXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `PGB_ASSERT_IMP(a_ready, clock, reset, !vld_ff[LAT-1], req.ready)
endmodule
`default_nettype wire
